[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define BF3_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("box filter assertion failed");

// property checked on every clock edge, reset included
`define BF3_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("box filter assertion failed");

`endif

[src/bf3_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bf3_pkg;

    // configuration register map
    localparam int          CFG_W         = 11;
    localparam int          PADDR_W       = 3;
    localparam logic [2:0]  REG_SIDE_ADDR = 3'd0;
    localparam int          SIDE_RESET    = 32;

    // one source pixel
    typedef struct packed {
        logic [15:0] in_red;
        logic [15:0] in_green;
        logic [15:0] in_blue;
    } t_pix_in;

    // one smoothed pixel
    typedef struct packed {
        logic [15:0] out_red;
        logic [15:0] out_green;
        logic [15:0] out_blue;
        logic [9:0]  out_row;
        logic [9:0]  out_col;
        logic        last_of_run;
    } t_pix_out;

endpackage

`default_nettype wire

[src/bf3_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module bf3_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // single write port, registered read that holds while idle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[src/box_filter_3x3_rgb.sv]
`timescale 1ns / 1ps
`default_nettype none
// 3x3 box filter for a square RGB image streamed in raster order.
// Input channel: i_in_valid / o_in_ready carry one source pixel per request.
// Output channel: o_out_valid / i_out_ready carry one smoothed pixel per request,
// with its row, column and a last flag on the final pixel of the frame.
// Configuration: APB write of image_side at address 0 restarts the frame;
// sides below 2 act as 2, above MAX_SIDE as MAX_SIDE.
// Path: an accepted request passes the fetch register, the window and the pipeline
// registers into the output register; output trails input by one row and one column.
// Throughput: one pixel per clock while results are taken. The result sequencer emits one
// result a cycle from the window while stage 0 can load, so a row-end pixel (2 results), and
// on the last row a pixel with 2 or 4 results, holds the input until its last result issues.
// The two line buffers are single-port-write RAMs with a registered read at the request.
// Reset clears the counters, window and pipeline, side goes back to 32;
// line buffers are not cleared (unwritten rows are never summed).
// When the receiver stalls, the pipeline fills and then drops o_in_ready.
module box_filter_3x3_rgb import bf3_pkg::*; #(
    parameter int MAX_SIDE     = 1024,
    parameter int CHANNEL_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output      logic                 o_in_ready,
    input  wire t_pix_in              i_in_data,
    output      logic                 o_out_valid,
    input  wire logic                 i_out_ready,
    output      t_pix_out             o_out_data,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [PADDR_W-1:0]   paddr,
    input  wire logic [31:0]          pwdata,
    output      logic [31:0]          prdata,
    output      logic                 pready
);

    localparam int CW       = $clog2(MAX_SIDE);
    localparam int CB       = CHANNEL_BITS;
    localparam int PW       = 3 * CB;
    localparam int RW       = CB + 2;
    localparam int SW       = CB + 4;
    localparam int K        = SW;
    localparam int M6       = (1 << K) / 6;
    localparam int M9       = (1 << K) / 9;
    localparam int PRW      = SW + K;
    localparam int RST_SIDE = (SIDE_RESET > MAX_SIDE) ? MAX_SIDE : SIDE_RESET;
    localparam int RST_LAST = RST_SIDE - 1;

    localparam logic [1:0] NC_4 = 2'd0;
    localparam logic [1:0] NC_6 = 2'd1;
    localparam logic [1:0] NC_9 = 2'd2;

    // configuration and position counters
    logic [CFG_W-1:0] r_side;
    logic [CW-1:0]    r_last_idx;
    logic [CW-1:0]    r_row;
    logic [CW-1:0]    r_col;
    logic             cfg_wr;
    int               side_v;

    // fetch stage
    logic             accept;
    logic             r_a_vld;
    logic [CB-1:0]    r_a_px [3];
    logic [CW-1:0]    r_a_row;
    logic [CW-1:0]    r_a_col;
    logic [PW-1:0]    up_rdata;
    logic [PW-1:0]    lo_rdata;
    logic [PW-1:0]    lo_wdata;
    logic             a_go;

    // window and result sequencer
    logic [CB-1:0]    r_win [3][3][3];
    logic [3:0]       r_mask;
    logic [CW-1:0]    r_j_row;
    logic [CW-1:0]    r_j_col;
    logic [3:0]       n_mask;
    logic [1:0]       kind;
    logic             issue;
    logic             mask_single;
    logic             a_lr;
    logic             a_lc;
    logic [CW-1:0]    s_row;
    logic [CW-1:0]    s_col;
    logic             row_lo;
    logic             row_hi;
    logic             col_lo;
    logic             col_hi;
    logic [CB-1:0]    s_pix [3][3][3];
    logic [1:0]       s_nc;

    // arithmetic pipeline
    logic             r_p0_vld;
    logic [CB-1:0]    r_p0_pix [3][3][3];
    logic [1:0]       r_p0_nc;
    logic [CW-1:0]    r_p0_row;
    logic [CW-1:0]    r_p0_col;
    logic             r_p0_last;
    logic             r_p1_vld;
    logic [RW-1:0]    r_p1_rs [3][3];
    logic [1:0]       r_p1_nc;
    logic [CW-1:0]    r_p1_row;
    logic [CW-1:0]    r_p1_col;
    logic             r_p1_last;
    logic             r_p2_vld;
    logic [SW-1:0]    r_p2_sum [3];
    logic [1:0]       r_p2_nc;
    logic [CW-1:0]    r_p2_row;
    logic [CW-1:0]    r_p2_col;
    logic             r_p2_last;
    logic             r_p3_vld;
    logic [PRW-1:0]   r_p3_prod [3];
    logic [SW-1:0]    r_p3_sum [3];
    logic [1:0]       r_p3_nc;
    logic [CW-1:0]    r_p3_row;
    logic [CW-1:0]    r_p3_col;
    logic             r_p3_last;
    logic             r_o_vld;
    t_pix_out         r_o_data;
    logic [CB-1:0]    mean [3];
    logic             ld_o;
    logic             ld_p3;
    logic             ld_p2;
    logic             ld_p1;
    logic             ld_p0;

    // stage load enables, each stage fills when empty or draining
    assign ld_o  = !r_o_vld  || i_out_ready;
    assign ld_p3 = !r_p3_vld || ld_o;
    assign ld_p2 = !r_p2_vld || ld_p3;
    assign ld_p1 = !r_p1_vld || ld_p2;
    assign ld_p0 = !r_p0_vld || ld_p1;

    // apb register port
    assign pready = 1'b1;
    assign prdata = 32'(r_side);
    assign cfg_wr = psel && penable && pwrite && (paddr == REG_SIDE_ADDR);

    always_comb begin
        side_v = int'(pwdata[CFG_W-1:0]);
        if (side_v < 2) begin
            side_v = 2;
        end else if (side_v > MAX_SIDE) begin
            side_v = MAX_SIDE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side     <= CFG_W'(SIDE_RESET);
            r_last_idx <= CW'(RST_LAST);
        end else if (cfg_wr) begin
            r_side     <= pwdata[CFG_W-1:0];
            r_last_idx <= CW'(side_v - 1);
        end
    end

    // input request and raster counters
    assign o_in_ready = !r_a_vld || a_go;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (cfg_wr) begin
            r_row <= '0;
            r_col <= '0;
        end else if (accept) begin
            if (r_col == r_last_idx) begin
                r_col <= '0;
                r_row <= (r_row == r_last_idx) ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (accept) begin
            r_a_vld <= 1'b1;
        end else if (a_go) begin
            r_a_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_px[0] <= i_in_data.in_red[CB-1:0];
            r_a_px[1] <= i_in_data.in_green[CB-1:0];
            r_a_px[2] <= i_in_data.in_blue[CB-1:0];
            r_a_row   <= r_row;
            r_a_col   <= r_col;
        end
    end

    // line buffers: read the column at the request, write back when it moves on
    assign lo_wdata = {r_a_px[2], r_a_px[1], r_a_px[0]};

    bf3_ram #(.WIDTH(PW), .DEPTH(MAX_SIDE)) u_line_upper (
        .i_clk   (i_clk),
        .i_we    (a_go),
        .i_waddr (r_a_col),
        .i_wdata (lo_rdata),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (up_rdata)
    );

    bf3_ram #(.WIDTH(PW), .DEPTH(MAX_SIDE)) u_line_lower (
        .i_clk   (i_clk),
        .i_we    (a_go),
        .i_waddr (r_a_col),
        .i_wdata (lo_wdata),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (lo_rdata)
    );

    // window moves on once the sequencer has no result left or issues its last result
    assign mask_single = (r_mask & (r_mask - 4'd1)) == 4'd0;
    assign issue       = (r_mask != 4'd0) && ld_p0;
    assign a_go        = r_a_vld && ((r_mask == 4'd0) || (mask_single && issue));
    assign a_lr        = r_a_row == r_last_idx;
    assign a_lc        = r_a_col == r_last_idx;

    always_comb begin
        priority if (r_mask[0]) begin
            kind = 2'd0;
        end else if (r_mask[1]) begin
            kind = 2'd1;
        end else if (r_mask[2]) begin
            kind = 2'd2;
        end else begin
            kind = 2'd3;
        end
    end

    always_comb begin
        n_mask = r_mask;
        if (issue) begin
            n_mask = r_mask & ~(4'd1 << kind);
        end
        if (a_go) begin
            n_mask[0] = (r_a_row != '0) && (r_a_col != '0);
            n_mask[1] = (r_a_row != '0) && (r_a_col != '0) && a_lr;
            n_mask[2] = (r_a_row != '0) && a_lc;
            n_mask[3] = (r_a_row != '0) && a_lc && a_lr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else begin
            r_mask <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_go) begin
            r_j_row <= r_a_row;
            r_j_col <= r_a_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    for (int ch = 0; ch < 3; ch++) begin
                        r_win[i][j][ch] <= '0;
                    end
                end
            end
        end else if (a_go) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            for (int ch = 0; ch < 3; ch++) begin
                r_win[0][2][ch] <= up_rdata[ch*CB +: CB];
                r_win[1][2][ch] <= lo_rdata[ch*CB +: CB];
                r_win[2][2][ch] <= r_a_px[ch];
            end
        end
    end

    // pick the clipped neighbourhood of the result being issued
    assign s_row  = kind[0] ? r_j_row : r_j_row - 1'b1;
    assign s_col  = kind[1] ? r_j_col : r_j_col - 1'b1;
    assign row_lo = s_row != '0;
    assign row_hi = s_row != r_last_idx;
    assign col_lo = s_col != '0;
    assign col_hi = s_col != r_last_idx;

    always_comb begin
        int  wi;
        int  wj;
        logic inc;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                wi  = i + int'(kind[0]);
                wj  = j + int'(kind[1]);
                inc = (wi <= 2) && (wj <= 2)
                      && ((i != 0) || row_lo) && ((i != 2) || row_hi)
                      && ((j != 0) || col_lo) && ((j != 2) || col_hi);
                if (wi > 2) begin
                    wi = 2;
                end
                if (wj > 2) begin
                    wj = 2;
                end
                for (int ch = 0; ch < 3; ch++) begin
                    s_pix[i][j][ch] = inc ? r_win[wi][wj][ch] : '0;
                end
            end
        end
        if (row_lo && row_hi && col_lo && col_hi) begin
            s_nc = NC_9;
        end else if ((row_lo && row_hi) || (col_lo && col_hi)) begin
            s_nc = NC_6;
        end else begin
            s_nc = NC_4;
        end
    end

    // stage 0: selected pixels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_vld <= 1'b0;
        end else if (ld_p0) begin
            r_p0_vld <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_p0_pix  <= s_pix;
            r_p0_nc   <= s_nc;
            r_p0_row  <= s_row;
            r_p0_col  <= s_col;
            r_p0_last <= kind == 2'd3;
        end
    end

    // stage 1: row sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
        end else if (ld_p1) begin
            r_p1_vld <= r_p0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_p1) begin
            for (int ch = 0; ch < 3; ch++) begin
                for (int i = 0; i < 3; i++) begin
                    r_p1_rs[ch][i] <= RW'(r_p0_pix[i][0][ch]) + RW'(r_p0_pix[i][1][ch])
                                      + RW'(r_p0_pix[i][2][ch]);
                end
            end
            r_p1_nc   <= r_p0_nc;
            r_p1_row  <= r_p0_row;
            r_p1_col  <= r_p0_col;
            r_p1_last <= r_p0_last;
        end
    end

    // stage 2: full sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_vld <= 1'b0;
        end else if (ld_p2) begin
            r_p2_vld <= r_p1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_p2) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_p2_sum[ch] <= SW'(r_p1_rs[ch][0]) + SW'(r_p1_rs[ch][1])
                                + SW'(r_p1_rs[ch][2]);
            end
            r_p2_nc   <= r_p1_nc;
            r_p2_row  <= r_p1_row;
            r_p2_col  <= r_p1_col;
            r_p2_last <= r_p1_last;
        end
    end

    // stage 3: reciprocal multiply
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_vld <= 1'b0;
        end else if (ld_p3) begin
            r_p3_vld <= r_p2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_p3) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_p3_prod[ch] <= PRW'(r_p2_sum[ch])
                                 * PRW'((r_p2_nc == NC_6) ? M6 : M9);
                r_p3_sum[ch]  <= r_p2_sum[ch];
            end
            r_p3_nc   <= r_p2_nc;
            r_p3_row  <= r_p2_row;
            r_p3_col  <= r_p2_col;
            r_p3_last <= r_p2_last;
        end
    end

    // stage 4: quotient correction, shift for the corner case
    always_comb begin
        logic [SW-1:0]  q;
        logic [SW+3:0]  qd;
        logic [SW+3:0]  rem;
        logic [SW+3:0]  dv;
        for (int ch = 0; ch < 3; ch++) begin
            q   = r_p3_prod[ch][PRW-1:K];
            qd  = (r_p3_nc == NC_6) ? ((SW+4)'(q) << 2) + ((SW+4)'(q) << 1)
                                    : ((SW+4)'(q) << 3) + (SW+4)'(q);
            dv  = (r_p3_nc == NC_6) ? (SW+4)'(6) : (SW+4)'(9);
            rem = (SW+4)'(r_p3_sum[ch]) - qd;
            if (r_p3_nc == NC_4) begin
                mean[ch] = r_p3_sum[ch][CB+1:2];
            end else begin
                mean[ch] = CB'(q + SW'(rem >= dv));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (ld_o) begin
            r_o_vld <= r_p3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_o) begin
            r_o_data.out_red     <= 16'(mean[0]);
            r_o_data.out_green   <= 16'(mean[1]);
            r_o_data.out_blue    <= 16'(mean[2]);
            r_o_data.out_row     <= 10'(r_p3_row);
            r_o_data.out_col     <= 10'(r_p3_col);
            r_o_data.last_of_run <= r_p3_last;
        end
    end

    assign o_out_valid = r_o_vld;
    assign o_out_data  = r_o_data;

endmodule

`default_nettype wire

[src/bf3_check.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bf3_check import bf3_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_out_valid,
    input  wire logic     i_out_ready,
    input  wire t_pix_out i_out_data
);

    // a stalled result holds
    `BF3_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))

    // reset empties the output register
    `BF3_ASSERT_ALWAYS(a_out_reset, i_clk, !i_rst_n |=> !i_out_valid)

    // the last flag only comes on a pixel whose row equals its column
    `BF3_ASSERT(a_last_corner, i_clk, i_rst_n, i_out_valid && i_out_data.last_of_run |-> i_out_data.out_row == i_out_data.out_col)

endmodule

bind box_filter_3x3_rgb bf3_check u_bf3_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import bf3_pkg::*;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    t_pix_in             i_in_data;
    logic                o_out_valid;
    logic                i_out_ready;
    t_pix_out            o_out_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    localparam int MAX_SIDE = 1024;

    box_filter_3x3_rgb u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // filter predictor state
    logic [47:0] upper_line [MAX_SIDE];
    logic [47:0] lower_line [MAX_SIDE];
    logic [47:0] win [3][3];
    int unsigned side_reg;
    int unsigned cur_row;
    int unsigned cur_col;

    t_pix_out smoothed_q[$];
    int       err_count;
    bit       hold_off;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #50ms;
        $display("tb_top: FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        err_count++;
    endtask

    function automatic int unsigned eff_side();
        if (side_reg < 2) return 2;
        if (side_reg > MAX_SIDE) return MAX_SIDE;
        return side_reg;
    endfunction

    // mean over clipped neighborhood around window cell (wr, wc)
    function automatic t_pix_out window_mean(int unsigned s, int orow, int ocol, int wr, int wc);
        t_pix_out res;
        int unsigned sr, sg, sb, n;
        sr = 0; sg = 0; sb = 0; n = 0;
        for (int dr = -1; dr <= 1; dr++)
            for (int dc = -1; dc <= 1; dc++)
                if (orow + dr >= 0 && orow + dr < int'(s) && wr + dr >= 0 && wr + dr <= 2 &&
                    ocol + dc >= 0 && ocol + dc < int'(s) && wc + dc >= 0 && wc + dc <= 2) begin
                    sr += win[wr+dr][wc+dc][47:32];
                    sg += win[wr+dr][wc+dc][31:16];
                    sb += win[wr+dr][wc+dc][15:0];
                    n++;
                end
        if (n == 0) n = 1;
        res.out_red     = 16'(sr / n);
        res.out_green   = 16'(sg / n);
        res.out_blue    = 16'(sb / n);
        res.out_row     = 10'(orow);
        res.out_col     = 10'(ocol);
        res.last_of_run = 1'b0;
        return res;
    endfunction

    // advance the window by one pixel and queue the smoothed pixels it releases
    task automatic predict_pixel(input t_pix_in px);
        int unsigned s, r, c;
        bit last_row, last_col;
        int k0;
        s = eff_side();
        r = (cur_row >= s) ? 0 : cur_row;
        c = (cur_col >= s) ? 0 : cur_col;
        last_row = (r == s - 1);
        last_col = (c == s - 1);
        k0 = smoothed_q.size();
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = upper_line[c];
        win[1][2] = lower_line[c];
        win[2][2] = px;
        upper_line[c] = lower_line[c];
        lower_line[c] = px;
        if (r >= 1 && c >= 1) begin
            smoothed_q.push_back(window_mean(s, r - 1, c - 1, 1, 1));
            if (last_row) smoothed_q.push_back(window_mean(s, r, c - 1, 2, 1));
        end
        if (r >= 1 && last_col) begin
            smoothed_q.push_back(window_mean(s, r - 1, c, 1, 2));
            if (last_row) smoothed_q.push_back(window_mean(s, r, c, 2, 2));
        end
        if (last_row && last_col && smoothed_q.size() > k0)
            smoothed_q[$].last_of_run = 1'b1;
        c++;
        if (c >= s) begin
            c = 0;
            r++;
            if (r >= s) r = 0;
        end
        cur_row = r;
        cur_col = c;
    endtask

    // apb write of the side register, restarts the frame
    task automatic write_side(input int unsigned val);
        i_in_valid <= 1'b0;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_SIDE_ADDR;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        side_reg = val & 32'h7ff;
        cur_row = 0;
        cur_col = 0;
    endtask

    // send one request, bursty gaps before it
    task automatic send_pixel(input t_pix_in px, input bit bursty);
        if (bursty && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 6)) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        i_in_valid <= 1'b1;
        i_in_data  <= px;
        predict_pixel(px);
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic idle_input();
        i_in_valid <= 1'b0;
    endtask

    // wait until all smoothed pixels are back, then let the pipeline drain
    task automatic drain();
        int guard;
        idle_input();
        guard = 0;
        while (smoothed_q.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        if (smoothed_q.size() != 0)
            report_mismatch("missing results", 0, smoothed_q.size());
        repeat (20) @(posedge i_clk);
    endtask

    function automatic t_pix_in rand_pixel();
        t_pix_in p;
        p.in_red   = 16'($urandom);
        p.in_green = 16'($urandom);
        p.in_blue  = 16'($urandom);
        return p;
    endfunction

    // one frame of random content, pixels with extreme values mixed in
    task automatic send_frame(input int unsigned s);
        t_pix_in p;
        for (int unsigned i = 0; i < s * s; i++) begin
            p = rand_pixel();
            case ($urandom_range(0, 7))
                0: p = '0;
                1: p = '1;
                default: ;
            endcase
            send_pixel(p, 1'b1);
        end
    endtask

    // receiver stall pattern plus one long hold-off
    initial begin
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                i_out_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            else if ($urandom_range(0, 99) < 60) i_out_ready <= 1'b1;
            else i_out_ready <= ($urandom_range(0, 3) != 0) ? 1'b0 : 1'b1;
        end
    end

    // output checker
    always @(posedge i_clk) begin
        t_pix_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (smoothed_q.size() == 0) begin
                report_mismatch("unexpected result row", o_out_data.out_row, -1);
            end
            else begin
                want = smoothed_q.pop_front();
                if (o_out_data.out_red !== want.out_red)
                    report_mismatch("red", o_out_data.out_red, want.out_red);
                if (o_out_data.out_green !== want.out_green)
                    report_mismatch("green", o_out_data.out_green, want.out_green);
                if (o_out_data.out_blue !== want.out_blue)
                    report_mismatch("blue", o_out_data.out_blue, want.out_blue);
                if (o_out_data.out_row !== want.out_row)
                    report_mismatch("row", o_out_data.out_row, want.out_row);
                if (o_out_data.out_col !== want.out_col)
                    report_mismatch("col", o_out_data.out_col, want.out_col);
                if (o_out_data.last_of_run !== want.last_of_run)
                    report_mismatch("last", o_out_data.last_of_run, want.last_of_run);
            end
        end
    end

    // directed table: a 2x2 frame of extremes, then a 3x3 frame
    t_pix_in dir_pix [13];

    initial begin
        t_pix_out first_want;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        err_count  = 0;
        hold_off   = 1'b0;
        side_reg   = SIDE_RESET;
        cur_row    = 0;
        cur_col    = 0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) win[i][j] = '0;
        dir_pix[0] = '1;
        dir_pix[1] = '1;
        dir_pix[2] = '1;
        dir_pix[3] = '1;
        dir_pix[4] = '{16'h0000, 16'hffff, 16'h5555};
        dir_pix[5] = '{16'hffff, 16'h0000, 16'haaaa};
        dir_pix[6] = '{16'h0001, 16'h8000, 16'h0000};
        dir_pix[7] = '{16'h8000, 16'h0001, 16'hffff};
        dir_pix[8] = '{16'hffff, 16'hffff, 16'h0000};
        dir_pix[9] = '{16'h0000, 16'h0000, 16'hffff};
        dir_pix[10] = '{16'h1234, 16'h5678, 16'h9abc};
        dir_pix[11] = '{16'hfedc, 16'hba98, 16'h7654};
        dir_pix[12] = '{16'h7fff, 16'h8001, 16'h0f0f};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // side below range acts as 2; an all-ones frame averages to all ones
        write_side(0);
        for (int i = 0; i < 4; i++) send_pixel(dir_pix[i], 1'b0);
        first_want = smoothed_q[0];
        if (first_want.out_red != 16'hffff || first_want.out_row != 0 || first_want.out_col != 0)
            report_mismatch("predictor corner", first_want.out_red, 16'hffff);
        drain();

        // 3x3 frame, written mid-way after a restart from a partial frame
        write_side(3);
        for (int i = 4; i < 8; i++) send_pixel(dir_pix[i], 1'b0);
        write_side(3);
        for (int i = 4; i < 13; i++) send_pixel(dir_pix[i], 1'b0);
        drain();

        // side above range acts as max: part of the first row, then restart
        write_side(2047);
        for (int i = 0; i < 116; i++) send_pixel(rand_pixel(), 1'b0);
        drain();

        // random frames with long receiver hold-off in the first one
        write_side(8);
        hold_off = 1'b1;
        send_frame(8);
        drain();
        write_side(2);
        repeat (6) send_frame(2);
        drain();
        write_side(5);
        repeat (4) send_frame(5);
        drain();
        write_side(7);
        send_frame(7);
        drain();

        if (err_count == 0) $display("tb_top: PASS");
        else $display("tb_top: FAIL");
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/bf3_pkg.sv
src/bf3_ram.sv
src/box_filter_3x3_rgb.sv
src/bf3_check.sv
verif/tb_top.sv
